// ===== hw/rtl/dfhf_pkg.sv =====
// dfhf_pkg: constants, codes and payload types of the dual frame hit finder
// no dependencies
package dfhf_pkg;
  localparam int NUM_CHANNELS = 64;
  localparam int NUM_SHEETS   = 4;
  localparam int GRID_SIZE    = 31;
  localparam int COUNT_BITS   = 32;
  localparam int SHEET_SIZE   = NUM_CHANNELS / NUM_SHEETS;
  localparam int HALF         = NUM_CHANNELS / 2;
  localparam int CELLS        = GRID_SIZE * GRID_SIZE;
  localparam int CELL_W       = $clog2(CELLS);
  localparam logic [31:0] HEADER_WORD = 32'hffffea0c;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] word;
    logic [5:0]  entry_index;
    logic [5:0]  map_target;
    logic [15:0] threshold;
    logic [15:0] pedestal;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] header_fault;
    logic [1:0] id_fault;
    logic       count_mismatch;
    logic       coincidence;
    logic [4:0] vec_x;
    logic [4:0] vec_y;
    logic       out_of_grid;
    logic [5:0] peak_chan_a;
    logic [5:0] peak_chan_b;
    logic [5:0] peak_chan_c;
    logic [5:0] peak_chan_d;
  } out_item_t;
endpackage

// ===== hw/rtl/dfhf_if.sv =====
// dfhf_if: valid/ready channel carrying one payload beat
// depends on dfhf_pkg
interface dfhf_in_if (input logic clk);
  dfhf_pkg::in_item_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfhf_out_if (input logic clk);
  dfhf_pkg::out_item_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dual_frame_hit_finder_top.sv =====
// dual_frame_hit_finder_top: two-board frame parser, sheet peak scan and hit histogram
// depends on dfhf_pkg and dfhf_if
//
// The block takes one input beat at a time and takes none while a result waits in the output
// register. A channel word of the first half of a frame holds off the next beat until its
// sample write lands, as that write follows the registered channel map read. A histogram read
// passes through ST_RDH and ST_HRD to the output register, and the next beat can be taken after
// ST_EMIT. The beat that closes frame two starts a peak scan over the 64 channels from the
// sample and table memories. Each sheet issues 16 reads, drains the last one and fetches the
// peak channel's tables in ST_EVAL. A read-modify-write of the histogram cell follows, then the
// summary is offered, also when a faulty header or id closes frame two. After reset a clearing
// pass writes zero into all 961 histogram cells and the 64 entries of each table, one cell a
// cycle, before the first beat is taken. Results leave through an output register.
module dual_frame_hit_finder_top (
  input logic clk,
  input logic rst_n,
  dfhf_in_if.sink   in_ch,
  dfhf_out_if.source out_ch
);
  import dfhf_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RDH   = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_EVAL  = 9'b000010000,
    ST_HRD   = 9'b000100000,
    ST_HWR   = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;

  // memories
  logic [15:0] samp_mem [NUM_CHANNELS];
  logic [5:0]  map_mem  [NUM_CHANNELS];
  logic [15:0] thr_mem  [NUM_CHANNELS];
  logic [15:0] ped_mem  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] hist_mem [CELLS];

  state_t state_r, state_nxt;
  logic [9:0] clr_r;
  logic [2:0] phase_r;
  logic [6:0] widx_r;
  logic [1:0] hdr_bad_r, id_bad_r;
  logic [15:0] cnt0_r, cnt1_r;
  out_item_t res_r;
  logic out_valid_r;
  in_item_t it_r;

  // scan state
  logic [6:0]  sidx_r;      // channel being issued
  logic        rd_v_r;      // read data valid this cycle
  logic [5:0]  rd_ch_r;
  logic [15:0] samp_q, ped_q, thr_q;
  logic signed [17:0] best_r, second_r;
  logic [5:0] bch_r, sch_r;
  logic [5:0] pk_r [NUM_SHEETS];
  logic all_r;
  logic [1:0] fin_sheet_r;
  logic fin_r;              // sheet finishing: waiting for threshold/pedestal of bch
  logic [CELL_W-1:0] cell_r;
  logic [COUNT_BITS-1:0] hist_q;

  // map read for readout words (registered read of the stored map)
  logic [5:0] map_q;
  logic       samp_we_r;
  logic [15:0] samp_wd_r;

  assign in_ch.ready = (state_r == ST_IDLE) && !samp_we_r && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  wire acc = in_ch.valid && in_ch.ready;
  in_item_t di;
  assign di = in_ch.data;

  logic frame;
  assign frame = phase_r[2];

  // memory read address for tables: scan channel or peak channel
  logic [5:0] tab_addr;
  always_comb begin
    if (fin_r) tab_addr = bch_r;
    else tab_addr = sidx_r[5:0];
  end

  always_ff @(posedge clk) begin
    samp_q <= samp_mem[tab_addr];
    ped_q  <= ped_mem[tab_addr];
    thr_q  <= thr_mem[tab_addr];
  end

  // readout position lookup
  logic [5:0] pos;
  assign pos = widx_r[5:0] + (frame ? 6'(HALF) : 6'd0);
  always_ff @(posedge clk) map_q <= map_mem[pos];

  // clearing and loading writes to tables
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR && clr_r < 10'(NUM_CHANNELS)) begin
      samp_mem[clr_r[5:0]] <= '0;
      map_mem[clr_r[5:0]]  <= '0;
      thr_mem[clr_r[5:0]]  <= '0;
      ped_mem[clr_r[5:0]]  <= '0;
    end else begin
      if (acc && di.operation == OP_LOAD) begin
        map_mem[di.entry_index] <= di.map_target;
        thr_mem[di.entry_index] <= di.threshold;
        ped_mem[di.entry_index] <= di.pedestal;
      end
      if (samp_we_r) samp_mem[map_q] <= samp_wd_r;
    end
  end

  // scan datapath: difference of sample and pedestal
  logic signed [17:0] d;
  assign d = $signed({2'b0, samp_q}) - $signed({2'b0, ped_q});

  // sheet check with the peak channel's tables
  logic signed [17:0] level, th;
  logic [5:0] span;
  logic ok;
  always_comb begin
    level = best_r + $signed({2'b0, ped_q});
    th = $signed({2'b0, thr_q});
    span = (bch_r > sch_r) ? bch_r - sch_r : sch_r - bch_r;
    ok = (level > th) && !((second_r > th) && (span > 6'd1));
  end

  // vector
  logic signed [7:0] vx, vy;
  assign vx = $signed({2'b0, pk_r[1]}) - $signed({2'b0, pk_r[3]}) + 8'sd47;
  assign vy = $signed({2'b0, pk_r[2]}) - $signed({2'b0, pk_r[0]}) - 8'sd17;
  logic in_grid;
  assign in_grid = (vx >= 0) && (vx < 8'(GRID_SIZE)) && (vy >= 0) && (vy < 8'(GRID_SIZE));

  // histogram memory, bumped only in the last cycle of the read-modify-write
  logic [CELL_W-1:0] h_addr;
  logic h_we;
  logic [COUNT_BITS-1:0] h_wd;
  always_comb begin
    h_we = 1'b0;
    h_wd = '0;
    h_addr = cell_r;
    if (state_r == ST_CLEAR) begin
      h_we = 1'b1;
      h_addr = CELL_W'(clr_r);
    end else if (state_r == ST_HWR && fin_r && rd_v_r) begin
      h_we = all_r && in_grid && (hist_q != COUNT_MAX);
      h_wd = hist_q + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_addr] <= h_wd;
    hist_q <= hist_mem[h_addr];
  end

  // result of a histogram read
  out_item_t hrd_res;
  always_comb begin
    hrd_res = '0;
    hrd_res.result_kind = 1'b1;
    hrd_res.vec_x = it_r.cell_x;
    hrd_res.vec_y = it_r.cell_y;
    if (it_r.cell_x < 5'(GRID_SIZE) && it_r.cell_y < 5'(GRID_SIZE))
      hrd_res.coincidence = (hist_q != '0);
    else hrd_res.out_of_grid = 1'b1;
  end

  // event summary
  out_item_t evt_res;
  always_comb begin
    evt_res = '0;
    evt_res.header_fault = hdr_bad_r;
    evt_res.id_fault = id_bad_r;
    evt_res.count_mismatch = (cnt0_r != cnt1_r);
    evt_res.coincidence = all_r;
    if (all_r && in_grid) begin
      evt_res.vec_x = vx[4:0];
      evt_res.vec_y = vy[4:0];
    end
    evt_res.out_of_grid = all_r && !in_grid;
    evt_res.peak_chan_a = pk_r[0];
    evt_res.peak_chan_b = pk_r[1];
    evt_res.peak_chan_c = pk_r[2];
    evt_res.peak_chan_d = pk_r[3];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == 10'(CELLS - 1)) state_nxt = ST_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      phase_r <= '0;
      widx_r <= '0;
      hdr_bad_r <= '0;
      id_bad_r <= '0;
      cnt0_r <= '0;
      cnt1_r <= '0;
      out_valid_r <= 1'b0;
      samp_we_r <= 1'b0;
      rd_v_r <= 1'b0;
      fin_r <= 1'b0;
      sidx_r <= '0;
    end else begin
      if (samp_we_r) samp_we_r <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          state_r <= state_nxt;
        end
        ST_IDLE: begin
          if (acc) begin
            it_r <= di;
            case (di.operation)
              OP_READ: begin
                cell_r <= CELL_W'(11'(di.cell_x) * 11'(GRID_SIZE) + 11'(di.cell_y));
                state_r <= ST_RDH;
              end
              OP_WORD: begin
                case (phase_r[1:0])
                  2'd0: begin
                    if (di.word == HEADER_WORD) phase_r <= {frame, 2'd1};
                    else begin
                      hdr_bad_r[frame] <= 1'b1;
                      if (!frame) phase_r <= 3'd4;
                      else begin
                        sidx_r <= '0; state_r <= ST_SCAN;
                      end
                    end
                  end
                  2'd1: phase_r <= {frame, 2'd2};
                  2'd2: begin
                    if (frame) cnt1_r <= di.word[31:16]; else cnt0_r <= di.word[31:16];
                    if (di.word[15:0] == 16'(frame) + 16'd1) begin
                      phase_r <= {frame, 2'd3};
                      widx_r <= '0;
                    end else begin
                      id_bad_r[frame] <= 1'b1;
                      if (!frame) phase_r <= 3'd4;
                      else begin
                        sidx_r <= '0; state_r <= ST_SCAN;
                      end
                    end
                  end
                  default: begin
                    if (widx_r < 7'(HALF)) begin
                      samp_we_r <= 1'b1;
                      samp_wd_r <= di.word[15:0];
                    end
                    if (widx_r == 7'(NUM_CHANNELS - 1)) begin
                      widx_r <= '0;
                      if (!frame) phase_r <= 3'd4;
                      else begin
                        sidx_r <= '0; state_r <= ST_WAIT;
                      end
                    end else widx_r <= widx_r + 1'b1;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        ST_WAIT: begin
          // pass on to the scan; the last sample write has already landed
          state_r <= ST_SCAN;
        end
        ST_RDH: state_r <= ST_HRD;
        ST_HRD: begin
          res_r <= hrd_res;
          out_valid_r <= 1'b1;
          state_r <= ST_EMIT;
        end
        ST_SCAN: begin
          // issue channel sidx_r; consume the channel read last cycle
          if (fin_r) begin
            fin_r <= 1'b0;
          end else if (rd_v_r) begin
            if (d > best_r) begin
              second_r <= best_r; sch_r <= bch_r; best_r <= d; bch_r <= rd_ch_r;
            end
          end
          if (rd_v_r && rd_ch_r[3:0] == 4'hf && !fin_r) begin
            // sheet done: fetch tables of the peak channel next
            rd_v_r <= 1'b0;
            fin_r <= 1'b1;
            fin_sheet_r <= rd_ch_r[5:4];
            state_r <= ST_EVAL;
          end else if (sidx_r < 7'(NUM_CHANNELS) && !fin_r) begin
            if (sidx_r[3:0] == 4'd0) begin
              // a sheet with no positive sample reports channel zero
              best_r <= '0; second_r <= '0; bch_r <= '0; sch_r <= '0;
              if (sidx_r == 7'd0) all_r <= 1'b1;
            end
            rd_v_r <= 1'b1;
            rd_ch_r <= sidx_r[5:0];
            sidx_r <= sidx_r + 1'b1;
          end else begin
            rd_v_r <= 1'b0;
          end
        end
        ST_EVAL: begin
          // tables for bch_r arrive once fin_r has dropped (address set while fin_r)
          if (fin_r) fin_r <= 1'b0;
          else begin
            if (!ok) all_r <= 1'b0;
            pk_r[fin_sheet_r] <= bch_r;
            if (fin_sheet_r == 2'(NUM_SHEETS - 1)) state_r <= ST_HWR;
            else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_HWR: begin
          // first pass sets address; cell read settles; then write
          if (!fin_r) begin
            cell_r <= CELL_W'(11'(vx[4:0]) * 11'(GRID_SIZE) + 11'(vy[4:0]));
            fin_r <= 1'b1;
            rd_v_r <= 1'b0;
          end else if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else begin
            fin_r <= 1'b0;
            rd_v_r <= 1'b0;
            res_r <= evt_res;
            out_valid_r <= 1'b1;
            phase_r <= '0;
            widx_r <= '0;
            hdr_bad_r <= '0;
            id_bad_r <= '0;
            sidx_r <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: if (!out_valid_r || out_ch.ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/dfhf_checker.sv =====
// dfhf_checker: port-level checks of the dual frame hit finder
// bound to dual_frame_hit_finder_top
module dfhf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_coin,
  input logic out_oog
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("beat taken while result waits");
  a_oog_coin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind && out_oog |-> out_coin) else $error("out of grid without hit");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind dual_frame_hit_finder_top dfhf_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.data.result_kind), .out_coin(out_ch.data.coincidence),
  .out_oog(out_ch.data.out_of_grid)
);

// ===== dv/tb.sv =====
// tb: self-checking bench for dual_frame_hit_finder_top, frame parsing, peak scan and histogram
// depends on dfhf_pkg, dfhf_if and the rtl top level
// an in-bench predictor tracks tables, samples and histogram; results are checked in order
module tb;
  import dfhf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // operation code that the block ignores
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 120;

  typedef enum logic [1:0] {SEEK_HEADER, SKIP_SPARE, TAKE_ID, TAKE_DATA} parse_step_t;

  logic clk;
  logic rst_n;

  dfhf_in_if  in_ch (clk);
  dfhf_out_if out_ch (clk);

  dual_frame_hit_finder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state, a private copy of everything the block remembers
  parse_step_t      step;
  logic             frame_two;
  int unsigned      data_count;
  logic [15:0]      sample_mem [NUM_CHANNELS];
  logic [5:0]       chan_map [NUM_CHANNELS];
  logic [15:0]      thresh_mem [NUM_CHANNELS];
  logic [15:0]      ped_mem [NUM_CHANNELS];
  logic [15:0]      board_count [2];
  logic [COUNT_BITS-1:0] hit_hist [CELLS];
  logic [1:0]       header_bad;
  logic [1:0]       id_bad;

  out_item_t        pending_results [$];
  int unsigned      beats_sent;
  int unsigned      mismatches;
  bit               calm;
  int unsigned      idle_cycles;
  int unsigned      out_stall;

  // sheet scan at the end of frame two, also bumps the histogram
  function automatic out_item_t close_event();
    out_item_t r;
    int best, second, bch, sch, d, level, th, span, vx, vy;
    bit all_ok;
    int peak [NUM_SHEETS];
    r = '0;
    all_ok = 1'b1;
    for (int s = 0; s < NUM_SHEETS; s++) begin
      best = 0;
      second = 0;
      bch = 0;
      sch = 0;
      for (int j = 0; j < SHEET_SIZE; j++) begin
        d = int'(sample_mem[j + s * SHEET_SIZE]) - int'(ped_mem[j + s * SHEET_SIZE]);
        if (d > best) begin
          second = best;
          sch = bch;
          best = d;
          bch = j + s * SHEET_SIZE;
        end
      end
      level = best + int'(ped_mem[bch]);
      th = int'(thresh_mem[bch]);
      span = (bch > sch) ? bch - sch : sch - bch;
      // valid peak if it clears the threshold, unless a far-away displaced peak also clears it
      if (!(level > th && !(second > th && span > 1))) all_ok = 1'b0;
      peak[s] = bch;
    end
    r.header_fault = header_bad;
    r.id_fault = id_bad;
    r.count_mismatch = (board_count[0] != board_count[1]);
    if (all_ok) begin
      vx = peak[1] - peak[3] + 47;
      vy = peak[2] - peak[0] - 17;
      r.coincidence = 1'b1;
      if (vx >= 0 && vx < GRID_SIZE && vy >= 0 && vy < GRID_SIZE) begin
        if (hit_hist[vx * GRID_SIZE + vy] != COUNT_MAX)
          hit_hist[vx * GRID_SIZE + vy] = hit_hist[vx * GRID_SIZE + vy] + 1'b1;
        r.vec_x = vx[4:0];
        r.vec_y = vy[4:0];
      end else begin
        r.out_of_grid = 1'b1;
      end
    end
    r.peak_chan_a = peak[0][5:0];
    r.peak_chan_b = peak[1][5:0];
    r.peak_chan_c = peak[2][5:0];
    r.peak_chan_d = peak[3][5:0];
    step = SEEK_HEADER;
    frame_two = 1'b0;
    data_count = 0;
    header_bad = '0;
    id_bad = '0;
    return r;
  endfunction

  // a frame ends early or normally: after frame one go look for frame two, after frame two close the event
  function automatic bit end_frame(output out_item_t r);
    if (!frame_two) begin
      step = SEEK_HEADER;
      frame_two = 1'b1;
      return 1'b0;
    end
    r = close_event();
    return 1'b1;
  endfunction

  function automatic bit predict_beat(in_item_t it, output out_item_t r);
    r = '0;
    case (it.operation)
      OP_LOAD: begin
        chan_map[it.entry_index] = it.map_target;
        thresh_mem[it.entry_index] = it.threshold;
        ped_mem[it.entry_index] = it.pedestal;
        return 1'b0;
      end
      OP_READ: begin
        r.result_kind = 1'b1;
        r.vec_x = it.cell_x;
        r.vec_y = it.cell_y;
        if (it.cell_x < GRID_SIZE && it.cell_y < GRID_SIZE)
          r.coincidence = (hit_hist[it.cell_x * GRID_SIZE + it.cell_y] != '0);
        else
          r.out_of_grid = 1'b1;
        return 1'b1;
      end
      OP_WORD: begin
        case (step)
          SEEK_HEADER: begin
            if (it.word == HEADER_WORD) begin
              step = SKIP_SPARE;
              return 1'b0;
            end
            header_bad[frame_two] = 1'b1;
            return end_frame(r);
          end
          SKIP_SPARE: begin
            step = TAKE_ID;
            return 1'b0;
          end
          TAKE_ID: begin
            board_count[frame_two] = it.word[31:16];
            if (it.word[15:0] == 16'(frame_two) + 16'd1) begin
              step = TAKE_DATA;
              data_count = 0;
              return 1'b0;
            end
            id_bad[frame_two] = 1'b1;
            return end_frame(r);
          end
          default: begin
            if (data_count < HALF)
              sample_mem[chan_map[(data_count + (frame_two ? HALF : 0)) % NUM_CHANNELS]] =
                it.word[15:0];
            data_count++;
            if (data_count >= NUM_CHANNELS) begin
              data_count = 0;
              return end_frame(r);
            end
            return 1'b0;
          end
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t noise_item(logic [1:0] op);
    logic [95:0] raw;
    in_item_t it;
    raw = {$urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  // one beat on the input channel, predicted once it is taken
  task automatic send_beat(in_item_t it);
    out_item_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (predict_beat(it, r)) pending_results.push_back(r);
  endtask

  task automatic send_word(logic [31:0] w);
    in_item_t it;
    it = noise_item(OP_WORD);
    it.word = w;
    send_beat(it);
  endtask

  task automatic load_entry(int idx, int target, int th, int ped);
    in_item_t it;
    it = noise_item(OP_LOAD);
    it.entry_index = idx[5:0];
    it.map_target = target[5:0];
    it.threshold = th[15:0];
    it.pedestal = ped[15:0];
    send_beat(it);
  endtask

  task automatic read_cell(int x, int y);
    in_item_t it;
    it = noise_item(OP_READ);
    it.cell_x = x[4:0];
    it.cell_y = y[4:0];
    send_beat(it);
  endtask

  // one board frame; channel values reach the sample memory through the current map
  task automatic send_frame(bit second_board, bit hdr_ok, bit id_ok, logic [15:0] count,
                            logic [15:0] chan_val [NUM_CHANNELS]);
    logic [15:0] id;
    int pos;
    send_word(hdr_ok ? HEADER_WORD : HEADER_WORD ^ (32'd1 << $urandom_range(0, 31)));
    if (!hdr_ok) return;
    send_word($urandom());
    id = second_board ? 16'd2 : 16'd1;
    if (!id_ok) id = id ^ 16'($urandom_range(1, 65535));
    send_word({count, id});
    if (!id_ok) return;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pos = i + (second_board ? HALF : 0);
      if (i < HALF)
        send_word({16'($urandom()), chan_val[chan_map[pos % NUM_CHANNELS]]});
      else
        send_word($urandom());
      // the odd histogram read or ignored beat in the middle of a frame
      if ($urandom_range(0, 40) == 0) read_cell($urandom_range(0, 31), $urandom_range(0, 31));
      if ($urandom_range(0, 80) == 0) send_beat(noise_item(OP_IDLE));
    end
  endtask

  task automatic send_event(bit h1, bit i1, bit h2, bit i2, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] chan_val [NUM_CHANNELS]);
    send_frame(1'b0, h1, i1, c1, chan_val);
    send_frame(1'b1, h2, i2, c2, chan_val);
  endtask

  // peak per sheet at a chosen channel, low noise elsewhere; some sheets all random, all zero or with two peaks
  task automatic make_samples(output logic [15:0] v [NUM_CHANNELS]);
    int pk;
    for (int s = 0; s < NUM_SHEETS; s++) begin
      pk = s * SHEET_SIZE + $urandom_range(0, SHEET_SIZE - 1);
      for (int j = s * SHEET_SIZE; j < (s + 1) * SHEET_SIZE; j++)
        v[j] = 16'($urandom_range(0, 60));
      case ($urandom_range(0, 9))
        0: for (int j = s * SHEET_SIZE; j < (s + 1) * SHEET_SIZE; j++) v[j] = 16'($urandom());
        1: for (int j = s * SHEET_SIZE; j < (s + 1) * SHEET_SIZE; j++) v[j] = '0;
        2: begin
          // two strong peaks far apart
          v[pk] = 16'($urandom_range(400, 65535));
          v[s * SHEET_SIZE + ((pk + 8) % SHEET_SIZE)] = 16'($urandom_range(300, 2000));
        end
        default: v[pk] = 16'($urandom_range(200, 65535));
      endcase
    end
  endtask

  task automatic load_tables(bit identity, int th_max, int ped_max);
    for (int i = 0; i < NUM_CHANNELS; i++)
      load_entry(i, identity ? i : $urandom_range(0, 63), $urandom_range(0, th_max),
                 $urandom_range(0, ped_max));
  endtask

  task automatic wait_drain();
    if (pending_results.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_cold_reads();
    // histogram starts clear; corners in and just outside the grid
    read_cell(0, 0);
    read_cell(30, 30);
    read_cell(31, 0);
    read_cell(0, 31);
    read_cell(31, 31);
    send_beat(noise_item(OP_IDLE));
  endtask

  task automatic test_table_extremes();
    logic [15:0] v [NUM_CHANNELS];
    load_entry(0, 0, 0, 65535);
    load_entry(63, 63, 65535, 0);
    // untouched samples with tables near reset give peaks of zero
    for (int i = 0; i < NUM_CHANNELS; i++) v[i] = '0;
    send_event(1, 1, 1, 1, 16'h0000, 16'h0000, v);
    load_tables(1'b1, 150, 0);
    make_samples(v);
    for (int i = 0; i < NUM_CHANNELS; i++) v[i] = '0;
    v[5] = 16'hffff; v[20] = 1000; v[40] = 900; v[55] = 800;
    send_event(1, 1, 1, 1, 16'hffff, 16'hffff, v);
    read_cell(20 - 55 + 47, 40 - 5 - 17);
  endtask

  task automatic test_frame_faults();
    logic [15:0] v [NUM_CHANNELS];
    make_samples(v);
    send_event(0, 1, 0, 1, 16'd1, 16'd1, v);
    send_event(0, 1, 1, 1, 16'd3, 16'd3, v);
    send_event(1, 0, 1, 1, 16'd4, 16'd4, v);
    send_event(1, 1, 1, 0, 16'd5, 16'd9, v);
    send_event(1, 1, 0, 1, 16'd7, 16'd7, v);
    send_event(1, 1, 1, 1, 16'd10, 16'd11, v);
    // hold the sender until the last summary is out
    wait_drain();
  endtask

  task automatic test_random_traffic();
    logic [15:0] v [NUM_CHANNELS];
    int kind;
    while (beats_sent < 1400) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) load_tables(1'b1, $urandom_range(0, 1) ? 150 : 65535, 40);
      else if (kind == 1) load_tables(1'b0, 300, 200);
      else if (kind == 2)
        load_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom(), $urandom());
      else if (kind == 3) send_beat(noise_item($urandom_range(0, 3)));
      else if (kind == 4) wait_drain();
      else begin
        make_samples(v);
        send_event($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                   $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                   16'($urandom()), $urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'hffff,
                   v);
      end
    end
  endtask

  task automatic test_histogram_sweep();
    // quiet tail: no idling, read random cells, then every third cell of the line y = 15
    calm = 1'b1;
    for (int i = 0; i < 12; i++) read_cell($urandom_range(0, 31), $urandom_range(0, 31));
    for (int i = 0; i < GRID_SIZE; i += 3) read_cell(i, 15);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_item_t want, got;
    string bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
        if (got.header_fault !== want.header_fault) bad = {bad, " header_fault"};
        if (got.id_fault !== want.id_fault) bad = {bad, " id_fault"};
        if (got.count_mismatch !== want.count_mismatch) bad = {bad, " count_mismatch"};
        if (got.coincidence !== want.coincidence) bad = {bad, " coincidence"};
        if (got.vec_x !== want.vec_x) bad = {bad, " vec_x"};
        if (got.vec_y !== want.vec_y) bad = {bad, " vec_y"};
        if (got.out_of_grid !== want.out_of_grid) bad = {bad, " out_of_grid"};
        if (got.peak_chan_a !== want.peak_chan_a) bad = {bad, " peak_chan_a"};
        if (got.peak_chan_b !== want.peak_chan_b) bad = {bad, " peak_chan_b"};
        if (got.peak_chan_c !== want.peak_chan_c) bad = {bad, " peak_chan_c"};
        if (got.peak_chan_d !== want.peak_chan_d) bad = {bad, " peak_chan_d"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch in%s\n  expected %p\n  actual   %p", bad, want, got);
        end
      end
    end
  end

  // receiver stalls in short bursts, none once the tail is calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      out_stall <= 0;
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= (out_stall == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    calm = 1'b0;
    beats_sent = 0;
    mismatches = 0;
    step = SEEK_HEADER;
    frame_two = 1'b0;
    data_count = 0;
    header_bad = '0;
    id_bad = '0;
    board_count[0] = '0;
    board_count[1] = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sample_mem[i] = '0;
      chan_map[i] = '0;
      thresh_mem[i] = '0;
      ped_mem[i] = '0;
    end
    for (int i = 0; i < CELLS; i++) hit_hist[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_cold_reads();
    test_table_extremes();
    test_frame_faults();
    test_random_traffic();
    test_histogram_sweep();

    wait_drain();
    in_ch.valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/dfhf_pkg.sv
hw/rtl/dfhf_if.sv
hw/rtl/dual_frame_hit_finder_top.sv
hw/rtl/dfhf_checker.sv
dv/tb.sv
